@@ sv/cssc_pkg.sv @@
`default_nettype none

package cssc_pkg;

	// Number of digits scanned and filled
	localparam int DIGITS = 8;
	localparam int IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int CNT_W  = $clog2(DIGITS + 1);

	// Frame layout: sixteen bits, three ticks each, then one long tick
	localparam int WORD_W     = 16;
	localparam int BITPOS_W   = $clog2(WORD_W + 1);
	localparam int LIMIT_W    = 16;
	localparam logic [LIMIT_W-1:0] IDLE_RESET = 16'd2000;
	localparam logic [LIMIT_W-1:0] IDLE_MAX   = 16'hFFFF;

	// Operation codes of an input item
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	// Phases within one bit
	localparam logic [1:0] PHASE_FALL = 2'd0;
	localparam logic [1:0] PHASE_RISE = 2'd1;
	localparam logic [1:0] PHASE_HOLD = 2'd2;

	// Power-up pattern shown before any byte arrives
	localparam logic [7:0] GREETING [8] = '{
		8'h02, 8'h6E, 8'h9E, 8'h1C, 8'h1C, 8'hFC, 8'h41, 8'h02
	};

	// Line behaviour for one tick
	typedef struct packed {
		logic level;
		logic glitch;
		logic latch;
		logic frame_end;
	} cssc_tick_t;

	// One result item
	typedef struct packed {
		logic       serial_level;
		logic       serial_glitch;
		logic       latch_pulse;
		logic       long_next_tick;
		logic       forward_valid;
		logic [7:0] forward_byte;
	} cssc_result_t;

	// Shift word: segment byte high, active-low digit select low
	function automatic logic [WORD_W-1:0] word_for(input logic [7:0] seg,
			input logic [IDX_W-1:0] d);
		logic [7:0] sel;
		sel = ~(8'h80 >> d);
		return {seg, sel};
	endfunction

endpackage

`default_nettype wire

@@ sv/cssc_in_if.sv @@
`default_nettype none

interface cssc_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] rx_byte;

	modport source (output valid, output operation, output rx_byte, input ready);
	modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ sv/cssc_out_if.sv @@
`default_nettype none

interface cssc_out_if;
	logic       valid;
	logic       ready;
	logic       serial_level;
	logic       serial_glitch;
	logic       latch_pulse;
	logic       long_next_tick;
	logic       forward_valid;
	logic [7:0] forward_byte;

	modport source (output valid, output serial_level, output serial_glitch,
		output latch_pulse, output long_next_tick, output forward_valid,
		output forward_byte, input ready);
	modport sink (input valid, input serial_level, input serial_glitch,
		input latch_pulse, input long_next_tick, input forward_valid,
		input forward_byte, output ready);
endinterface

`default_nettype wire

@@ sv/cssc_tick_decode.sv @@
`default_nettype none

module cssc_tick_decode (
	input  wire logic [cssc_pkg::WORD_W-1:0]   shift_word,
	input  wire logic [cssc_pkg::BITPOS_W-1:0] bit_pos,
	input  wire logic [1:0]                    phase,
	input  wire logic                          line_state,
	output cssc_pkg::cssc_tick_t               tick
);

	logic bit_val;
	logic in_word;

	assign in_word = (bit_pos < cssc_pkg::BITPOS_W'(cssc_pkg::WORD_W));
	assign bit_val = shift_word[bit_pos[$clog2(cssc_pkg::WORD_W)-1:0]];

	// Drive the shift clock line for the current phase
	always_comb begin
		tick.level     = line_state;
		tick.glitch    = 1'b0;
		tick.latch     = 1'b0;
		tick.frame_end = !in_word;
		if (in_word) begin
			case (phase)
				cssc_pkg::PHASE_FALL: begin
					tick.level  = bit_val;
					tick.glitch = bit_val;
				end
				cssc_pkg::PHASE_RISE: begin
					tick.level = 1'b1;
				end
				default: begin
					tick.level = line_state;
				end
			endcase
			tick.latch = (bit_pos == cssc_pkg::BITPOS_W'(cssc_pkg::WORD_W - 1))
				&& (phase == cssc_pkg::PHASE_HOLD);
		end
	end

endmodule

`default_nettype wire

@@ sv/chained_seven_segment_scanner.sv @@
// Multiplexed seven-segment scanner with a daisy-chained byte input.
//
// in_ch carries one item per event: operation selects a timer tick or a
// received serial byte (rx_byte). out_ch returns exactly one result item per
// input item: the shift clock line level, glitch, latch and long-tick flags
// for ticks, and the forwarded byte once all digit registers are filled.
// cfg_write_en/cfg_write_data set the idle limit, in frames, after which the
// next byte restarts filling at digit zero.
//
// The result sits in the output register in the cycle after the item is
// taken. Throughput is one item per cycle while the receiver keeps up; the
// state update and result are one short step of logic. in_ch.ready stays high
// while the output register is empty or being emptied, so a stalled
// receiver holds the result and back-pressures the input after one item.
//
// Reset loads the greeting pattern into the digits, the word for digit zero
// into the shift register, raises the line and sets the idle limit to 2000.
`default_nettype none

module chained_seven_segment_scanner (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	cssc_in_if.sink                            in_ch,
	cssc_out_if.source                         out_ch,
	input  wire logic                          cfg_write_en,
	input  wire logic [cssc_pkg::LIMIT_W-1:0]  cfg_write_data
);

	logic [7:0]                    digits_q [cssc_pkg::DIGITS];
	logic [cssc_pkg::WORD_W-1:0]   shift_word_q;
	logic [cssc_pkg::IDX_W-1:0]    digit_idx_q;
	logic [cssc_pkg::BITPOS_W-1:0] bit_pos_q;
	logic [1:0]                    phase_q;
	logic [cssc_pkg::CNT_W-1:0]    taken_q;
	logic [cssc_pkg::LIMIT_W-1:0]  idle_q;
	logic [cssc_pkg::LIMIT_W-1:0]  limit_q;
	logic                          line_q;
	logic                          out_valid_q;
	cssc_pkg::cssc_result_t        res_q;

	cssc_pkg::cssc_tick_t          tick;
	logic                          accept;
	logic                          is_byte;
	logic [cssc_pkg::CNT_W-1:0]    taken_eff;
	logic                          digits_full;
	logic [cssc_pkg::IDX_W-1:0]    next_idx;

	cssc_tick_decode u_tick (
		.shift_word (shift_word_q),
		.bit_pos    (bit_pos_q),
		.phase      (phase_q),
		.line_state (line_q),
		.tick       (tick)
	);

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_byte     = (in_ch.operation == cssc_pkg::OP_BYTE);

	// Restart the fill count after a long enough silence
	assign taken_eff   = (idle_q > limit_q) ? '0 : taken_q;
	assign digits_full = (taken_eff >= cssc_pkg::CNT_W'(cssc_pkg::DIGITS));

	assign next_idx = (digit_idx_q == cssc_pkg::IDX_W'(cssc_pkg::DIGITS - 1))
		? '0 : digit_idx_q + 1'b1;

	// Hold the idle limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= cssc_pkg::IDLE_RESET;
		end else if (cfg_write_en) begin
			limit_q <= cfg_write_data;
		end
	end

	// Fill digit registers from received bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cssc_pkg::DIGITS; i++) begin
				digits_q[i] <= cssc_pkg::GREETING[i];
			end
		end else if (accept && is_byte && !digits_full) begin
			digits_q[taken_eff[cssc_pkg::IDX_W-1:0]] <= in_ch.rx_byte;
		end
	end

	// Advance the scan and byte bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_word_q <= cssc_pkg::word_for(cssc_pkg::GREETING[0], '0);
			digit_idx_q  <= '0;
			bit_pos_q    <= '0;
			phase_q      <= cssc_pkg::PHASE_FALL;
			taken_q      <= '0;
			idle_q       <= '0;
			line_q       <= 1'b1;
		end else if (accept) begin
			if (is_byte) begin
				idle_q <= '0;
				taken_q <= digits_full ? cssc_pkg::CNT_W'(cssc_pkg::DIGITS)
					: taken_eff + 1'b1;
			end else if (tick.frame_end) begin
				if (idle_q != cssc_pkg::IDLE_MAX) begin
					idle_q <= idle_q + 1'b1;
				end
				digit_idx_q  <= next_idx;
				shift_word_q <= cssc_pkg::word_for(digits_q[next_idx], next_idx);
				bit_pos_q    <= '0;
				phase_q      <= cssc_pkg::PHASE_FALL;
			end else begin
				line_q <= tick.level;
				if (phase_q == cssc_pkg::PHASE_HOLD) begin
					phase_q   <= cssc_pkg::PHASE_FALL;
					bit_pos_q <= bit_pos_q + 1'b1;
				end else begin
					phase_q <= phase_q + 1'b1;
				end
			end
		end
	end

	// Track the output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result item
	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_byte) begin
				res_q.serial_level   <= line_q;
				res_q.serial_glitch  <= 1'b0;
				res_q.latch_pulse    <= 1'b0;
				res_q.long_next_tick <= 1'b0;
				res_q.forward_valid  <= digits_full;
				res_q.forward_byte   <= digits_full ? in_ch.rx_byte : 8'h00;
			end else begin
				res_q.serial_level   <= tick.frame_end ? line_q : tick.level;
				res_q.serial_glitch  <= tick.glitch;
				res_q.latch_pulse    <= tick.latch;
				res_q.long_next_tick <= tick.latch;
				res_q.forward_valid  <= 1'b0;
				res_q.forward_byte   <= 8'h00;
			end
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.serial_level   = res_q.serial_level;
	assign out_ch.serial_glitch  = res_q.serial_glitch;
	assign out_ch.latch_pulse    = res_q.latch_pulse;
	assign out_ch.long_next_tick = res_q.long_next_tick;
	assign out_ch.forward_valid  = res_q.forward_valid;
	assign out_ch.forward_byte   = res_q.forward_byte;

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int FRAME_LAST = 48;
	localparam int LATCH_TICK = 47;
	localparam int STALL_LIMIT = 1000;

	logic clk;
	logic arst_n;
	logic cfg_write_en;
	logic [cssc_pkg::LIMIT_W-1:0] cfg_write_data;

	cssc_in_if in_ch ();
	cssc_out_if out_ch ();

	chained_seven_segment_scanner dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (in_ch),
		.out_ch         (out_ch),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	// Shadow copy of the scanner state
	logic [7:0]                   seg_shadow [8];
	logic [cssc_pkg::WORD_W-1:0]  word_shadow;
	int                           digit_shadow;
	int                           tick_shadow;
	int                           taken_shadow;
	logic [cssc_pkg::LIMIT_W-1:0] idle_shadow;
	logic                         line_shadow;
	logic [cssc_pkg::LIMIT_W-1:0] limit_shadow;

	cssc_pkg::cssc_result_t expected_lines [$];

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int result_count;
	int stall_cycles;

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [cssc_pkg::WORD_W-1:0] digit_word(input int d);
		logic [7:0] sel;
		sel = 8'hFF;
		sel[7 - d] = 1'b0;
		return {seg_shadow[d], sel};
	endfunction

	task automatic reset_shadow();
		for (int i = 0; i < 8; i++)
			seg_shadow[i] = cssc_pkg::GREETING[i];
		digit_shadow = 0;
		word_shadow = digit_word(0);
		tick_shadow = 0;
		taken_shadow = 0;
		idle_shadow = '0;
		line_shadow = 1'b1;
		limit_shadow = cssc_pkg::IDLE_RESET;
	endtask

	// Advance the shadow state by one item and queue the line it produces
	task automatic predict_scan(input logic op, input logic [7:0] b);
		cssc_pkg::cssc_result_t r;
		int bit_pos;
		logic [1:0] ph;
		r = '0;
		if (op == cssc_pkg::OP_BYTE) begin
			if (idle_shadow > limit_shadow)
				taken_shadow = 0;
			idle_shadow = '0;
			if (taken_shadow < cssc_pkg::DIGITS) begin
				seg_shadow[taken_shadow] = b;
				taken_shadow++;
			end else begin
				r.forward_valid = 1'b1;
				r.forward_byte = b;
			end
		end else if (tick_shadow < FRAME_LAST) begin
			bit_pos = tick_shadow / 3;
			ph = 2'(tick_shadow % 3);
			if (ph == cssc_pkg::PHASE_FALL) begin
				line_shadow = word_shadow[bit_pos];
				r.serial_glitch = word_shadow[bit_pos];
			end else if (ph == cssc_pkg::PHASE_RISE) begin
				line_shadow = 1'b1;
			end
			if (tick_shadow == LATCH_TICK) begin
				r.latch_pulse = 1'b1;
				r.long_next_tick = 1'b1;
			end
			tick_shadow++;
		end else begin
			// long tick: close the frame and load the next digit
			if (idle_shadow != cssc_pkg::IDLE_MAX)
				idle_shadow++;
			digit_shadow = (digit_shadow + 1) % cssc_pkg::DIGITS;
			word_shadow = digit_word(digit_shadow);
			tick_shadow = 0;
		end
		r.serial_level = line_shadow;
		expected_lines.push_back(r);
	endtask

	task automatic report_mismatch(input string msg);
		$display("tb_top: mismatch at result %0d: %s", result_count, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Send one item, idling first at random; returns at the accepting edge
	task automatic send_item(input logic op, input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.rx_byte <= b;
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
		predict_scan(op, b);
	endtask

	// Drop valid and hold until every expected line has come back
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (expected_lines.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_idle_limit(input logic [cssc_pkg::LIMIT_W-1:0] v);
		wait_drained();
		cfg_write_en <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		limit_shadow = v;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom());
		endcase
	endfunction

	// Mixed traffic: runs of ticks, bursts of bytes and scattered noise
	task automatic run_mixed(input int n, input int long_pct);
		int sent;
		int kind;
		int len;
		sent = 0;
		while (sent < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				len = ($urandom_range(0, 99) < long_pct) ?
					$urandom_range(49, 220) : $urandom_range(1, 30);
				if (len > n - sent)
					len = n - sent;
				repeat (len) send_item(cssc_pkg::OP_TICK, 8'($urandom()));
			end else if (kind < 85) begin
				len = $urandom_range(1, 12);
				if (len > n - sent)
					len = n - sent;
				repeat (len) send_item(cssc_pkg::OP_BYTE, pick_byte());
			end else begin
				len = $urandom_range(1, 10);
				if (len > n - sent)
					len = n - sent;
				repeat (len) send_item(1'($urandom_range(0, 1)), pick_byte());
			end
			sent += len;
		end
	endtask

	// Field extremes, a byte during a frame, filling and forwarding
	task automatic test_directed();
		logic [7:0] fill [8] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA,
			8'h0F, 8'hF0};
		repeat (3) send_item(cssc_pkg::OP_TICK, 8'hFF);
		foreach (fill[i]) begin
			send_item(cssc_pkg::OP_BYTE, fill[i]);
			if (i == 1)
				send_item(cssc_pkg::OP_TICK, 8'h00);
		end
		send_item(cssc_pkg::OP_BYTE, 8'hFF);
		send_item(cssc_pkg::OP_BYTE, 8'h00);
		repeat (3) send_item(cssc_pkg::OP_TICK, 8'h5A);
	endtask

	task automatic test_scan_frames(input int n);
		run_mixed(n, 70);
	endtask

	task automatic test_idle_restart(input logic [cssc_pkg::LIMIT_W-1:0] lim,
			input int n);
		write_idle_limit(lim);
		run_mixed(n, 35);
	endtask

	// Hold off the sender mid-stream until the block has emptied
	task automatic test_pause_drain(input int n);
		run_mixed(n / 2, 35);
		wait_drained();
		run_mixed(n - n / 2, 35);
	endtask

	// Receiver stalls
	always @(posedge clk)
		out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// Compare each line taken from the block; watch for a hang
	always @(negedge clk) begin
		cssc_pkg::cssc_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_lines.size() == 0) begin
				report_mismatch("unexpected result item");
			end else begin
				want = expected_lines.pop_front();
				check_field("serial_level", 8'(out_ch.serial_level),
					8'(want.serial_level));
				check_field("serial_glitch", 8'(out_ch.serial_glitch),
					8'(want.serial_glitch));
				check_field("latch_pulse", 8'(out_ch.latch_pulse),
					8'(want.latch_pulse));
				check_field("long_next_tick", 8'(out_ch.long_next_tick),
					8'(want.long_next_tick));
				check_field("forward_valid", 8'(out_ch.forward_valid),
					8'(want.forward_valid));
				check_field("forward_byte", out_ch.forward_byte, want.forward_byte);
			end
			result_count++;
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		result_count = 0;
		stall_cycles = 0;
		send_idle_pct = 22;
		recv_idle_pct = 76;
		arst_n <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_write_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= cssc_pkg::OP_TICK;
		in_ch.rx_byte <= '0;
		reset_shadow();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_idle_restart(16'd0, 300);
		test_scan_frames(300);

		send_idle_pct = 76;
		recv_idle_pct = 22;
		test_idle_restart(cssc_pkg::IDLE_MAX, 250);
		test_pause_drain(60);
		test_idle_restart(16'd1, 300);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_idle_restart(16'd3, 350);
		test_idle_restart(cssc_pkg::IDLE_RESET, 400);

		wait_drained();
		repeat (5) @(posedge clk);
		if (error_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/cssc_pkg.sv
sv/cssc_in_if.sv
sv/cssc_out_if.sv
sv/cssc_tick_decode.sv
sv/chained_seven_segment_scanner.sv
test/tb_top.sv
